>>> rtl/core/rvb_pkg.sv
// Shared types and constants for the stereo Schroeder reverberator.
// No dependencies; imported by most other files, though not by the sample and result interfaces or the port checks.
package rvb_pkg;

   localparam int SAMPLE_BITS_DEF   = 16;
   localparam int INTERNAL_BITS_DEF = 24;

   localparam int NUM_RINGS  = 9;
   localparam int RING_DEPTH = 8703;
   localparam int RING_AW    = 14;
   localparam int POS_W      = 12;
   localparam int UNIT_W     = 4;
   localparam int GAIN_W     = 15;
   localparam int MIX_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DW     = 16;

   // Ring order: allpass a,b,c, comb a..d, left and right decorrelation.
   localparam logic [RING_AW-1:0] RING_BASE [NUM_RINGS] =
      '{14'd0, 14'd389, 14'd516, 14'd559, 14'd2336, 14'd4183, 14'd6176, 14'd8313, 14'd8524};
   localparam logic [POS_W-1:0] RING_LEN [NUM_RINGS] =
      '{12'd389, 12'd127, 12'd43, 12'd1777, 12'd1847, 12'd1993, 12'd2137, 12'd211, 12'd179};

   localparam logic [UNIT_W-1:0] UNIT_AP_LAST  = 4'd2;
   localparam logic [UNIT_W-1:0] UNIT_CB_FIRST = 4'd3;
   localparam logic [UNIT_W-1:0] UNIT_CB_LAST  = 4'd6;
   localparam logic [UNIT_W-1:0] UNIT_DL       = 4'd7;
   localparam logic [UNIT_W-1:0] UNIT_DR       = 4'd8;

   localparam logic [17:0] AP_GAIN = 18'd22938;
   localparam logic [MIX_W-1:0] UNITY = 16'd32768;

   localparam logic [GAIN_W-1:0] GAIN0_RST = 15'd24804;
   localparam logic [GAIN_W-1:0] GAIN1_RST = 15'd24534;
   localparam logic [GAIN_W-1:0] GAIN2_RST = 15'd23980;
   localparam logic [GAIN_W-1:0] GAIN3_RST = 15'd23445;
   localparam logic [MIX_W-1:0]  WET_RST   = 16'd9830;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN0 = 3'd0,
      CSR_GAIN1 = 3'd1,
      CSR_GAIN2 = 3'd2,
      CSR_GAIN3 = 3'd3,
      CSR_WET   = 3'd4,
      CSR_LPEN  = 3'd5
   } rvb_csr_type;

   typedef enum logic [3:0] {
      PH_IDLE, PH_AP_MUL, PH_AP_ADD, PH_AP_WR, PH_AP_OUT,
      PH_CB_MUL, PH_CB_ADD, PH_CB_WR, PH_LP, PH_DL_WR, PH_DR_WR,
      PH_MIX_D, PH_MIX_L, PH_MIX_R, PH_MIX_O
   } rvb_phase_type;

   typedef struct packed {
      rvb_phase_type     phase;
      logic [UNIT_W-1:0] unit;
      logic              cap;
      logic [UNIT_W-1:0] cap_unit;
      logic              cap_zero;
   } rvb_ctl_type;

endpackage

>>> rtl/core/rvb_req_if.sv
// Input channel: one audio sample per transfer.
// Depends on nothing.
interface rvb_req_if #(parameter int SB = 16);
   logic          valid;
   logic          ready;
   logic [SB-1:0] sample_in;
   modport source (output valid, sample_in, input ready);
   modport sink   (input valid, sample_in, output ready);
endinterface

>>> rtl/core/rvb_rsp_if.sv
// Result channel: left, right and mono samples per transfer.
// Depends on nothing.
interface rvb_rsp_if #(parameter int SB = 16);
   logic          valid;
   logic          ready;
   logic [SB-1:0] left_out;
   logic [SB-1:0] right_out;
   logic [SB-1:0] mono_out;
   modport source (output valid, left_out, right_out, mono_out, input ready);
   modport sink   (input valid, left_out, right_out, mono_out, output ready);
endinterface

>>> rtl/core/rvb_csr_if.sv
// Register write channel: index and data per transfer.
// Uses rvb_pkg for the field widths.
interface rvb_csr_if import rvb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DW-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/rvb_delay_mem.sv
// Single memory holding all nine delay rings, read-before-write at one address.
// Uses rvb_pkg for depth and address width.
module rvb_delay_mem import rvb_pkg::*; #(
   parameter int DW = INTERNAL_BITS_DEF
) (
   input  logic               clock,
   input  logic               we,
   input  logic [RING_AW-1:0] addr,
   input  logic [DW-1:0]      wdata,
   output logic [DW-1:0]      rdata
);
   logic [DW-1:0] mem [RING_DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      rdata_ff <= mem[addr];
      if (we) begin
         mem[addr] <= wdata;
      end
   end

   assign rdata = rdata_ff;
endmodule

>>> rtl/core/rvb_seq.sv
// Sequencer: phase state machine, ring positions and memory addressing.
// Uses rvb_pkg for the phase type, the control struct and the ring table.
module rvb_seq import rvb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic               out_free,
   output logic               req_ready,
   output logic               out_load,
   output logic               mem_we,
   output logic [RING_AW-1:0] mem_addr,
   output rvb_ctl_type        ctl
);
   rvb_phase_type     phase_ff, phase_in;
   logic [UNIT_W-1:0] unit_ff, unit_in;
   logic [POS_W-1:0]  pos_ff [NUM_RINGS];
   logic [NUM_RINGS-1:0] wrap_ff;
   logic              cap_ff, cap_zero_ff;
   logic [UNIT_W-1:0] cap_unit_ff;
   logic [POS_W-1:0]  pos_cur;

   always_comb begin
      phase_in = phase_ff;
      unit_in  = unit_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (req_fire) begin
               phase_in = PH_AP_MUL;
               unit_in  = '0;
            end
         end
         PH_AP_MUL: phase_in = PH_AP_ADD;
         PH_AP_ADD: phase_in = PH_AP_WR;
         PH_AP_WR:  phase_in = PH_AP_OUT;
         PH_AP_OUT: begin
            phase_in = (unit_ff == UNIT_AP_LAST) ? PH_CB_MUL : PH_AP_MUL;
            unit_in  = unit_ff + 4'd1;
         end
         PH_CB_MUL: phase_in = PH_CB_ADD;
         PH_CB_ADD: phase_in = PH_CB_WR;
         PH_CB_WR: begin
            phase_in = (unit_ff == UNIT_CB_LAST) ? PH_LP : PH_CB_MUL;
            unit_in  = unit_ff + 4'd1;
         end
         PH_LP:     phase_in = PH_DL_WR;
         PH_DL_WR: begin
            phase_in = PH_DR_WR;
            unit_in  = unit_ff + 4'd1;
         end
         PH_DR_WR:  phase_in = PH_MIX_D;
         PH_MIX_D:  phase_in = PH_MIX_L;
         PH_MIX_L:  phase_in = PH_MIX_R;
         PH_MIX_R:  phase_in = PH_MIX_O;
         PH_MIX_O:  phase_in = out_free ? PH_IDLE : PH_MIX_O;
         default:   phase_in = PH_IDLE;
      endcase
   end

   assign pos_cur = pos_ff[unit_ff];

   always_comb begin
      req_ready = (phase_ff == PH_IDLE);
      out_load  = (phase_ff == PH_MIX_O) && out_free;
      mem_we    = (phase_ff == PH_AP_WR) || (phase_ff == PH_CB_WR) ||
                  (phase_ff == PH_DL_WR) || (phase_ff == PH_DR_WR);
      mem_addr  = RING_BASE[unit_ff] + {2'b00, pos_cur};
      ctl.phase    = phase_ff;
      ctl.unit     = unit_ff;
      ctl.cap      = cap_ff;
      ctl.cap_unit = cap_unit_ff;
      ctl.cap_zero = cap_zero_ff;
   end

   // An entry holds data only once its ring has wrapped; before that it reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         unit_ff     <= '0;
         wrap_ff     <= '0;
         cap_ff      <= 1'b0;
         cap_unit_ff <= '0;
         cap_zero_ff <= 1'b0;
         for (int i = 0; i < NUM_RINGS; i++) begin
            pos_ff[i] <= '0;
         end
      end else begin
         phase_ff    <= phase_in;
         unit_ff     <= unit_in;
         cap_ff      <= mem_we;
         cap_unit_ff <= unit_ff;
         cap_zero_ff <= !wrap_ff[unit_ff];
         if (mem_we) begin
            if (pos_cur == RING_LEN[unit_ff] - 12'd1) begin
               pos_ff[unit_ff]  <= '0;
               wrap_ff[unit_ff] <= 1'b1;
            end else begin
               pos_ff[unit_ff] <= pos_cur + 12'd1;
            end
         end
      end
   end
endmodule

>>> rtl/core/rvb_dp.sv
// Datapath: shared multiplier, line taps, comb sum, lowpass and output mix.
// Uses rvb_pkg for the phase type, control struct and gain constants.
module rvb_dp import rvb_pkg::*; #(
   parameter int SB = SAMPLE_BITS_DEF,
   parameter int IB = INTERNAL_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  rvb_ctl_type       ctl,
   input  logic              req_fire,
   input  logic [SB-1:0]     sample_in,
   input  logic [GAIN_W-1:0] gain [4],
   input  logic [MIX_W-1:0]  wet_mix,
   input  logic              lowpass_enable,
   input  logic [IB-1:0]     mem_rdata,
   output logic [IB-1:0]     mem_wdata,
   output logic [SB-1:0]     left_out,
   output logic [SB-1:0]     right_out,
   output logic [SB-1:0]     mono_out
);
   localparam int PW = IB + 18;
   localparam int RW = IB + 3;
   localparam int SW = IB + 5;
   localparam int HW = IB + 2;
   localparam logic signed [SW-1:0] I_MAX = SW'((64'sd1 <<< (IB - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] I_MIN = -I_MAX - SW'(1);
   localparam logic signed [SW-1:0] S_MAX = SW'((64'sd1 <<< (SB - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] S_MIN = -S_MAX - SW'(1);

   function automatic logic signed [IB-1:0] sat_int(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] r;
      r = v;
      if (v > I_MAX) r = I_MAX;
      if (v < I_MIN) r = I_MIN;
      return r[IB-1:0];
   endfunction

   function automatic logic signed [SB-1:0] sat_smp(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] r;
      r = v;
      if (v > S_MAX) r = S_MAX;
      if (v < S_MIN) r = S_MIN;
      return r[SB-1:0];
   endfunction

   logic signed [IB-1:0] tap_ff [NUM_RINGS];
   logic signed [IB-1:0] val_ff, v_ff;
   logic signed [SB-1:0] x_ff, left_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [RW-1:0] dry_ff;
   logic signed [HW-1:0] sum_ff, h0_ff, h1_ff;

   logic signed [IB-1:0] mul_a, tap_cur, x_ext, c_val, filt;
   logic signed [17:0]   mul_b;
   logic [MIX_W-1:0]     wet, dry;
   logic signed [PW-1:0] prod_bias;
   logic signed [RW-1:0] rnd;
   logic signed [SW-1:0] lp_sum;
   logic [UNIT_W-1:0]    gidx;
   logic signed [SB-1:0] right_val;

   assign tap_cur   = tap_ff[ctl.unit];
   assign x_ext     = IB'(x_ff);
   assign wet       = (wet_mix > UNITY) ? UNITY : wet_mix;
   assign dry       = UNITY - wet;
   assign gidx      = ctl.unit - UNIT_CB_FIRST;
   assign prod_bias = prod_ff + PW'(16384);
   assign rnd       = prod_bias[PW-1:15];
   assign c_val     = sat_int(SW'(v_ff) + SW'(rnd));
   assign lp_sum    = SW'(sum_ff) + (SW'(h0_ff) <<< 1) + SW'(h1_ff) + SW'(2);
   assign filt      = lowpass_enable ? sat_int(lp_sum >>> 2) : sat_int(SW'(sum_ff));
   assign mem_wdata = val_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ctl.phase)
         PH_AP_MUL: begin
            mul_a = tap_cur;
            mul_b = AP_GAIN;
         end
         PH_AP_WR: begin
            mul_a = val_ff;
            mul_b = AP_GAIN;
         end
         PH_CB_MUL: begin
            mul_a = tap_cur;
            mul_b = {3'b000, gain[gidx[1:0]]};
         end
         PH_MIX_D: begin
            mul_a = x_ext;
            mul_b = {2'b00, dry};
         end
         PH_MIX_L: begin
            mul_a = tap_ff[UNIT_DL];
            mul_b = {2'b00, wet};
         end
         // The right product is held while the result waits for the output register.
         PH_MIX_R, PH_MIX_O: begin
            mul_a = tap_ff[UNIT_DR];
            mul_b = {2'b00, wet};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      right_val = sat_smp(SW'(rnd) + SW'(dry_ff));
      left_out  = left_ff;
      right_out = right_val;
      mono_out  = sat_smp((SW'(left_ff) + SW'(right_val) + SW'(1)) >>> 1);
   end

   always_ff @(posedge clock) begin
      prod_ff <= PW'(mul_a) * PW'(mul_b);
      if (req_fire) begin
         x_ff   <= sample_in;
         v_ff   <= IB'($signed(sample_in));
      end
      unique case (ctl.phase)
         PH_AP_ADD: val_ff <= c_val;
         PH_AP_OUT: v_ff   <= sat_int(SW'(tap_cur) - SW'(rnd));
         PH_CB_ADD: val_ff <= c_val;
         PH_LP:     val_ff <= filt;
         PH_MIX_L:  dry_ff <= rnd;
         PH_MIX_R:  left_ff <= sat_smp(SW'(rnd) + SW'(dry_ff));
         default: begin
         end
      endcase
   end

   // Taps and lowpass history are part of the filter state and clear at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         h0_ff  <= '0;
         h1_ff  <= '0;
         for (int i = 0; i < NUM_RINGS; i++) begin
            tap_ff[i] <= '0;
         end
      end else begin
         if (ctl.cap) begin
            tap_ff[ctl.cap_unit] <= ctl.cap_zero ? '0 : mem_rdata;
         end
         if (req_fire) begin
            sum_ff <= '0;
         end else if (ctl.phase == PH_CB_ADD) begin
            sum_ff <= sum_ff + HW'(c_val);
         end
         if (ctl.phase == PH_LP) begin
            h1_ff <= h0_ff;
            h0_ff <= sum_ff;
         end
      end
   end
endmodule

>>> rtl/core/schroeder_reverb_stereo.sv
// Top level of the stereo Schroeder reverberator: registers, sequencer,
// datapath, delay memory and result register. Uses rvb_pkg and the channel interfaces.
//
//   channel  | dir | payload                         | transfer when
//   req_chan | in  | sample_in                       | valid && ready
//   rsp_chan | out | left_out, right_out, mono_out   | valid && ready
//   csr_chan | in  | index, data                     | valid && ready (ready always high)
//
// An item passes through nine ring read-modify-write slots on the single delay memory
// and thirteen passes through the one shared multiplier, in sequence.
// Reset clears all filter state at once; rings read zero until they first wrap.
// A result waits in the output register; the next item may start meanwhile and
// stalls only in its final cycle if the previous result is still untaken.
module schroeder_reverb_stereo import rvb_pkg::*; #(
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int INTERNAL_BITS = INTERNAL_BITS_DEF
) (
   input logic    clock,
   input logic    reset,
   rvb_req_if.sink   req_chan,
   rvb_rsp_if.source rsp_chan,
   rvb_csr_if.sink   csr_chan
);
   logic [GAIN_W-1:0] gain_ff [4];
   logic [MIX_W-1:0]  wet_ff;
   logic              lpen_ff;
   logic              rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] left_ff, right_ff, mono_ff;
   logic [SAMPLE_BITS-1:0] left_val, right_val, mono_val;

   rvb_ctl_type        ctl;
   logic               req_ready, req_fire, out_free, out_load, mem_we;
   logic [RING_AW-1:0] mem_addr;
   logic [INTERNAL_BITS-1:0] mem_wdata, mem_rdata;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = req_ready;
   assign req_fire = req_chan.valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff[0] <= GAIN0_RST;
         gain_ff[1] <= GAIN1_RST;
         gain_ff[2] <= GAIN2_RST;
         gain_ff[3] <= GAIN3_RST;
         wet_ff     <= WET_RST;
         lpen_ff    <= 1'b0;
      end else if (csr_chan.valid) begin
         unique case (rvb_csr_type'(csr_chan.index))
            CSR_GAIN0: gain_ff[0] <= csr_chan.data[GAIN_W-1:0];
            CSR_GAIN1: gain_ff[1] <= csr_chan.data[GAIN_W-1:0];
            CSR_GAIN2: gain_ff[2] <= csr_chan.data[GAIN_W-1:0];
            CSR_GAIN3: gain_ff[3] <= csr_chan.data[GAIN_W-1:0];
            CSR_WET:   wet_ff     <= csr_chan.data;
            CSR_LPEN:  lpen_ff    <= csr_chan.data[0];
            default: begin
            end
         endcase
      end
   end

   rvb_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .out_free  (out_free),
      .req_ready (req_ready),
      .out_load  (out_load),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .ctl       (ctl)
   );

   rvb_dp #(.SB(SAMPLE_BITS), .IB(INTERNAL_BITS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .req_fire       (req_fire),
      .sample_in      (req_chan.sample_in),
      .gain           (gain_ff),
      .wet_mix        (wet_ff),
      .lowpass_enable (lpen_ff),
      .mem_rdata      (mem_rdata),
      .mem_wdata      (mem_wdata),
      .left_out       (left_val),
      .right_out      (right_val),
      .mono_out       (mono_val)
   );

   rvb_delay_mem #(.DW(INTERNAL_BITS)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         left_ff  <= left_val;
         right_ff <= right_val;
         mono_ff  <= mono_val;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.left_out  = left_ff;
   assign rsp_chan.right_out = right_ff;
   assign rsp_chan.mono_out  = mono_ff;
endmodule

>>> rtl/core/rvb_checker.sv
// Port-level checks for the reverberator, attached to the top level by bind.
// Depends on schroeder_reverb_stereo and its channel interfaces.
module rvb_port_assert (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic csr_ready
);
   // A transfer starts a multi-cycle item, so the input closes straight after.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input still open after a transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("register port not ready");
endmodule

bind schroeder_reverb_stereo rvb_port_assert u_rvb_port_assert (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .csr_ready (csr_chan.ready)
);

>>> bench/rvb_checker.sv
// Checker for the stereo reverberator: watches the sample, result and register
// channels, predicts each result and compares it. Depends on rvb_pkg and the interfaces.
`timescale 1ns / 1ps
module rvb_checker import rvb_pkg::*; (
   input logic clock,
   input logic reset,
   rvb_req_if.sink  req_mon,
   rvb_rsp_if.sink  rsp_mon,
   rvb_csr_if.sink  csr_mon,
   output int       fail_count,
   output int       pending
);

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic signed [15:0] mono;
   } stereo_type;

   localparam int LINE_LEN [9] = '{389, 127, 43, 1777, 1847, 1993, 2137, 211, 179};
   localparam int LINE_MAX = 2137;

   longint line_mem [9][LINE_MAX];
   int     line_pos [9];
   longint line_out [7];
   longint sum_hist [2];
   logic [14:0] comb_gain [4];
   logic [15:0] wet_share;
   logic        lp_on;
   stereo_type  expected_q [$];

   function automatic longint clip(longint v, int bits);
      longint lim;
      lim = longint'(1) << (bits - 1);
      if (v > lim - 1) return lim - 1;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // Round half up, then arithmetic shift (floor).
   function automatic longint round_shift(longint p, int s);
      return (p + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint rotate_line(int slot, longint w);
      longint old;
      old = line_mem[slot][line_pos[slot]];
      line_mem[slot][line_pos[slot]] = w;
      line_pos[slot] = (line_pos[slot] + 1 >= LINE_LEN[slot]) ? 0 : line_pos[slot] + 1;
      return old;
   endfunction

   function automatic stereo_type reverb_sample(logic signed [15:0] smp);
      longint x, v, t, w, c, acc, filt, dl, dr, wet, dry, l, r, m;
      stereo_type res;
      x = smp;
      v = x;
      for (int k = 0; k < 3; k++) begin
         t = line_out[k];
         w = clip(v + round_shift(t * 22938, 15), 24);
         line_out[k] = rotate_line(k, w);
         v = clip(t - round_shift(w * 22938, 15), 24);
      end
      acc = 0;
      for (int k = 0; k < 4; k++) begin
         c = clip(v + round_shift(line_out[3 + k] * longint'(comb_gain[k]), 15), 24);
         line_out[3 + k] = rotate_line(3 + k, c);
         acc += c;
      end
      if (lp_on) filt = clip(round_shift(acc + 2 * sum_hist[0] + sum_hist[1], 2), 24);
      else filt = clip(acc, 24);
      sum_hist[1] = sum_hist[0];
      sum_hist[0] = acc;
      dl = rotate_line(7, filt);
      dr = rotate_line(8, filt);
      wet = (wet_share > 16'd32768) ? 32768 : longint'(wet_share);
      dry = 32768 - wet;
      l = clip(round_shift(dl * wet, 15) + round_shift(x * dry, 15), 16);
      r = clip(round_shift(dr * wet, 15) + round_shift(x * dry, 15), 16);
      m = clip(round_shift(l + r, 1), 16);
      res.left  = l[15:0];
      res.right = r[15:0];
      res.mono  = m[15:0];
      return res;
   endfunction

   always @(posedge clock) begin
      stereo_type want;
      if (reset) begin
         foreach (line_mem[i, j]) line_mem[i][j] = 0;
         foreach (line_pos[i]) line_pos[i] = 0;
         foreach (line_out[i]) line_out[i] = 0;
         sum_hist = '{0, 0};
         comb_gain = '{GAIN0_RST, GAIN1_RST, GAIN2_RST, GAIN3_RST};
         wet_share = WET_RST;
         lp_on = 1'b0;
         expected_q.delete();
         fail_count = 0;
         pending = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_GAIN0: comb_gain[0] = csr_mon.data[14:0];
               CSR_GAIN1: comb_gain[1] = csr_mon.data[14:0];
               CSR_GAIN2: comb_gain[2] = csr_mon.data[14:0];
               CSR_GAIN3: comb_gain[3] = csr_mon.data[14:0];
               CSR_WET:   wet_share = csr_mon.data;
               CSR_LPEN:  lp_on = csr_mon.data[0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            expected_q.push_back(reverb_sample(req_mon.sample_in));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               $error("result transfer with no expectation waiting");
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_mon.left_out !== want.left) begin
                  $error("left_out: expected %0d, got %0d", want.left,
                         $signed(rsp_mon.left_out));
                  fail_count++;
               end
               if (rsp_mon.right_out !== want.right) begin
                  $error("right_out: expected %0d, got %0d", want.right,
                         $signed(rsp_mon.right_out));
                  fail_count++;
               end
               if (rsp_mon.mono_out !== want.mono) begin
                  $error("mono_out: expected %0d, got %0d", want.mono,
                         $signed(rsp_mon.mono_out));
                  fail_count++;
               end
            end
         end
         pending = expected_q.size();
      end
   end

endmodule

>>> bench/tb_top.sv
// Testbench top for the stereo reverberator: clock, reset, stimulus and verdict.
// Depends on rvb_pkg, the channel interfaces, the block and rvb_checker.
`timescale 1ns / 1ps
module tb_top;
   import rvb_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   idle_cycles;
   bit   long_hold;

   rvb_req_if #(16) req_chan ();
   rvb_rsp_if #(16) rsp_chan ();
   rvb_csr_if       csr_chan ();

   schroeder_reverb_stereo uut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   rvb_checker chk (
      .clock(clock), .reset(reset),
      .req_mon(req_chan.sink), .rsp_mon(rsp_chan.sink), .csr_mon(csr_chan.sink),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: its own stall pattern, plus one long hold-off on request.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (400) @(negedge clock);
            long_hold = 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= ($urandom_range(0, 1) == 1);
         end
      end
   end

   // Watchdog: cycles in which no transfer happens on any channel.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_sample(logic [15:0] s);
      req_chan.valid <= 1'b1;
      req_chan.sample_in <= s;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(rvb_csr_type idx, logic [15:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= val;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // Bursts of random length with random gaps; some bursts run without gaps.
   task automatic sample_burst(int count, int kind);
      int left;
      left = count;
      while (left > 0) begin
         int len;
         len = $urandom_range(1, 24);
         for (int i = 0; i < len && left > 0; i++, left--) begin
            case (kind)
               0: send_sample(16'($urandom));
               1: send_sample(16'($signed($urandom_range(0, 2000)) - 1000));
               default: send_sample(($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000);
            endcase
         end
         if ($urandom_range(0, 2) != 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge clock);
         end
      end
   endtask

   initial begin
      logic [15:0] edge_vals [10];
      reset = 1'b1;
      long_hold = 1'b0;
      idle_cycles = 0;
      req_chan.valid = 1'b0;
      req_chan.sample_in = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = CSR_GAIN0;
      csr_chan.data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes, single bits and an impulse at reset settings.
      edge_vals = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001,
                    16'h5555, 16'hAAAA, 16'h7FFF, 16'h7FFF, 16'h8000};
      foreach (edge_vals[i]) send_sample(edge_vals[i]);
      for (int b = 0; b < 16; b++) send_sample(16'(1) << b);
      drain_results();

      // Loudest settings: maximum feedback, wet above unity, lowpass on.
      write_reg(CSR_GAIN0, 16'h7FFF);
      write_reg(CSR_GAIN1, 16'hFFFF);
      write_reg(CSR_GAIN2, 16'h7FFF);
      write_reg(CSR_GAIN3, 16'h7FFF);
      write_reg(CSR_WET, 16'hFFFF);
      write_reg(CSR_LPEN, 16'h0001);
      sample_burst(120, 2);
      // Long hold-off on the result side while samples keep coming.
      long_hold = 1'b1;
      sample_burst(150, 0);
      drain_results();

      // Zero feedback, fully wet at unity, lowpass off.
      write_reg(CSR_GAIN0, 16'h0000);
      write_reg(CSR_GAIN1, 16'h0000);
      write_reg(CSR_GAIN2, 16'h0000);
      write_reg(CSR_GAIN3, 16'h0000);
      write_reg(CSR_WET, 16'd32768);
      write_reg(CSR_LPEN, 16'h0000);
      sample_burst(150, 0);
      drain_results();

      // Fully dry.
      write_reg(CSR_WET, 16'h0000);
      sample_burst(100, 0);
      drain_results();

      // Random settings for the rest.
      for (int ph = 0; ph < 5; ph++) begin
         write_reg(CSR_GAIN0, 16'($urandom));
         write_reg(CSR_GAIN1, 16'($urandom));
         write_reg(CSR_GAIN2, 16'($urandom));
         write_reg(CSR_GAIN3, 16'($urandom));
         write_reg(CSR_WET, 16'($urandom_range(0, 40000)));
         write_reg(CSR_LPEN, 16'($urandom));
         sample_burst(130, ph % 2);
         drain_results();
      end

      drain_results();
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
